// ----- src/brent_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brent_pkg
// Shared constants, codes and types of the Brent line minimizer.
// ----------------------------------------------------------------------------
package brent_pkg;

	localparam int WORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	localparam int FIELD_W = 32;
	localparam int TOL_W   = 16;
	localparam int ITER_W  = 10;
	localparam int CNT_W   = 11;
	localparam int IDX_W   = 2;
	localparam int IN_DATA_W  = 7 * FIELD_W;
	localparam int OUT_DATA_W = 112;

	localparam logic [TOL_W-1:0]  TOL_RESET   = 16'd66;
	localparam logic [ITER_W-1:0] LIMIT_RESET = 10'd100;

	// 1/golden ratio squared as a Q0.32 fraction
	localparam logic [63:0] GOLD_Q32 = 64'd1640531527;

	localparam logic [IDX_W-1:0] REG_TOL     = 2'd0;
	localparam logic [IDX_W-1:0] REG_LIMIT   = 2'd1;
	localparam logic [IDX_W-1:0] REG_VARIANT = 2'd2;

	localparam logic OP_START  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;
	localparam logic VAR_ORIG  = 1'b0;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_WAIT_INIT,
		PH_WAIT_SAMPLE,
		PH_DONE
	} phase_t;

	typedef enum logic [4:0] {
		S_IDLE, S_ST1, S_ST2, S_HEAD, S_TOL, S_CHK,
		S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9,
		S_GOLD, S_GOLD2, S_DIV, S_DIVC, S_STEP
	} seq_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ----- src/brent_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brent_div
// Restoring fixed-point divider, one quotient bit per cycle, saturating.
// ----------------------------------------------------------------------------
module brent_div import brent_pkg::*; #(
	parameter int W = WORD_WIDTH_DEF,
	parameter int F = FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [W-1:0] num,
	input  logic signed [W-1:0] den,
	output logic signed [W-1:0] quo,
	output div_stat_t           stat
);

	localparam int NW = W + F;
	localparam int CW = $clog2(NW + 1);

	logic          busy_q, done_q, neg_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  rem_q, den_q;
	logic [NW-1:0] num_q, quo_q;
	logic [W:0]    trial;
	logic [NW-1:0] lim, mag;
	logic [W-1:0]  num_mag, den_mag;

	assign num_mag = num[W-1] ? W'(-num) : W'(num);
	assign den_mag = den[W-1] ? W'(-den) : W'(den);
	assign trial   = {rem_q, num_q[NW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {num_mag, {F{1'b0}}};
			den_q <= den_mag;
			rem_q <= '0;
			quo_q <= '0;
			neg_q <= num[W-1] ^ den[W-1];
		end else if (busy_q) begin
			num_q <= {num_q[NW-2:0], 1'b0};
			if (trial >= {1'b0, den_q}) begin
				rem_q <= W'(trial - {1'b0, den_q});
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end

	// clamp to the word range, one more on the negative side
	assign lim  = {{(F+1){1'b0}}, {(W-1){1'b1}}} + {{(NW-1){1'b0}}, neg_q};
	assign mag  = (quo_q > lim) ? lim : quo_q;
	assign quo  = neg_q ? -$signed(mag[W-1:0]) : $signed(mag[W-1:0]);
	assign stat = '{busy: busy_q, done: done_q};

endmodule

// ----- src/brent_line_minimizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brent_line_minimizer
// Brent minimization on a bracket, function values supplied by handshake.
// ----------------------------------------------------------------------------
// Usage: a beat on s_* with tuser = start loads the bracket (points and
// values in tdata); each later beat with tuser = sample returns f at the
// point last asked for. Every start beat and every sample beat taken while
// a search runs gives one beat on m_*: tuser low carries the next point to
// evaluate, tuser high reports the best point, its value and the converged
// flag. A sample beat with no search running is taken and dropped.
// Every product of a step, whether golden-section or parabolic, goes in
// turn through the single shared saturating multiplier; a parabolic step
// that is taken also runs the bit-serial divider, which forms W + F
// quotient bits (48 at Q16.16). A done beat comes from S_HEAD at the
// iteration limit and from S_CHK when the tolerance is met; the first
// request of a revised start comes from S_ST1 and S_ST2. s_tready is high
// only while the sequencer is idle.
// A result waits in the output register while m_tready is low; the next
// item can be taken meanwhile and its result stalls until the register
// frees. cfg_* writes (tolerance, iteration limit, variant) are taken
// every cycle and are meant for idle periods. Reset clears the sequencer,
// the output valid and restores the register defaults.
// ----------------------------------------------------------------------------
module brent_line_minimizer import brent_pkg::*; #(
	parameter int WORD_WIDTH    = WORD_WIDTH_DEF,
	parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// left_point, middle_point, right_point, left_value, middle_value,
	// right_value, sample_value
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic                  s_tuser,   // op
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// request_point, converged, best_point, best_value, evaluation_count, pad
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tuser,   // done_res
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [IDX_W-1:0]      cfg_index,
	input  logic [TOL_W-1:0]      cfg_data
);

	localparam int W  = WORD_WIDTH;
	localparam int F  = FRACTION_BITS;
	localparam int EW = (W > FIELD_W) ? W : FIELD_W;
	localparam logic signed [W-1:0] FXMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] FXMIN = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [W-1:0] ONE   = {{(W-1){1'b0}}, 1'b1};
	localparam logic [63:0] INVG_WIDE = ((GOLD_Q32 << F) + 64'h8000_0000) >> 32;
	localparam logic signed [W-1:0] INVG  = INVG_WIDE[W-1:0];

	function automatic logic signed [W-1:0] fadd(input logic signed [W-1:0] a,
		input logic signed [W-1:0] b);
		logic [W:0] s;
		s = {a[W-1], a} + {b[W-1], b};
		if (s[W] != s[W-1]) return s[W] ? FXMIN : FXMAX;
		return s[W-1:0];
	endfunction

	function automatic logic signed [W-1:0] fsub(input logic signed [W-1:0] a,
		input logic signed [W-1:0] b);
		logic [W:0] s;
		s = {a[W-1], a} - {b[W-1], b};
		if (s[W] != s[W-1]) return s[W] ? FXMIN : FXMAX;
		return s[W-1:0];
	endfunction

	function automatic logic signed [W-1:0] fabs(input logic signed [W-1:0] a);
		if (a == FXMIN) return FXMAX;
		return a[W-1] ? -a : a;
	endfunction

	function automatic logic signed [W-1:0] fhalf(input logic signed [W-1:0] a);
		logic signed [W-1:0] t;
		t = a + $signed({{(W-1){1'b0}}, a[W-1]});
		return t >>> 1;
	endfunction

	function automatic logic signed [W-1:0] fmul(input logic signed [W-1:0] a,
		input logic signed [W-1:0] b);
		logic [W-1:0]   am, bm, mg;
		logic [2*W-1:0] pr, sh, lim;
		logic           neg;
		am  = a[W-1] ? W'(-a) : W'(a);
		bm  = b[W-1] ? W'(-b) : W'(b);
		neg = a[W-1] ^ b[W-1];
		pr  = (2*W)'(am) * (2*W)'(bm);
		sh  = pr >> F;
		lim = {{(W+1){1'b0}}, {(W-1){1'b1}}} + {{(2*W-1){1'b0}}, neg};
		mg  = (sh > lim) ? lim[W-1:0] : sh[W-1:0];
		return neg ? -$signed(mg) : $signed(mg);
	endfunction

	function automatic logic signed [W-1:0] in_word(input logic signed [FIELD_W-1:0] v);
		logic signed [EW-1:0] ex, mx, mn;
		ex = EW'(v);
		mx = EW'(FXMAX);
		mn = EW'(FXMIN);
		if (ex > mx) return FXMAX;
		if (ex < mn) return FXMIN;
		return ex[W-1:0];
	endfunction

	function automatic logic [FIELD_W-1:0] out_word(input logic signed [W-1:0] v);
		logic signed [EW-1:0] ex;
		ex = EW'(v);
		return ex[FIELD_W-1:0];
	endfunction

	// configuration
	logic [TOL_W-1:0]  tol_q;
	logic [ITER_W-1:0] limit_q;
	logic              variant_q;

	// control
	seq_t              st_q, st_d;
	phase_t            phase_q;
	logic [ITER_W-1:0] iter_q;
	logic [CNT_W-1:0]  eval_q, eval_inc;
	logic              m_tvalid_q;

	// datapath
	logic signed [W-1:0] lo_q, hi_q, x_q, fx_q, w_q, fw_q, v_q, fv_q;
	logic signed [W-1:0] step_now_q, e_q, pend_q, d_q, olde_q;
	logic signed [W-1:0] span_q, xm_q, tol1_q, tol2_q, r_q, q_q, p_q, t_q, mp_q;
	logic                c_q;

	// output register
	logic [FIELD_W-1:0] req_q, bp_q, bv_q;
	logic               done_q, conv_q;
	logic [CNT_W-1:0]   cnt_q;

	// shared multiplier operands
	logic signed [W-1:0] ma, mb;

	logic signed [W-1:0] in_l, in_m, in_r, in_fl, in_fm, in_fr, in_fs;
	logic signed [W-1:0] in_lo, in_hi, tolf, span, t1, gold_e, u_div, u_st1, u_step;
	logic [W+F-1:0]      tol_ext;
	logic [F+TOL_W-1:0]  tol_sh;
	logic                acc, orig, force_par, out_free, lim_hit, conv_hit, para;
	logic                near, c1, c2, c3;
	logic                em_req, em_done, em_conv;
	logic signed [W-1:0] em_u;
	logic                div_start;
	logic signed [W-1:0] div_quo;
	div_stat_t           div_stat;

	assign in_l  = in_word(s_tdata[31:0]);
	assign in_m  = in_word(s_tdata[63:32]);
	assign in_r  = in_word(s_tdata[95:64]);
	assign in_fl = in_word(s_tdata[127:96]);
	assign in_fm = in_word(s_tdata[159:128]);
	assign in_fr = in_word(s_tdata[191:160]);
	assign in_fs = in_word(s_tdata[223:192]);
	assign in_lo = (in_l < in_r) ? in_l : in_r;
	assign in_hi = (in_l > in_r) ? in_l : in_r;

	assign tol_sh  = {tol_q, {F{1'b0}}};
	assign tol_ext = (W+F)'(tol_sh[F+TOL_W-1:TOL_W]);
	assign tolf    = (tol_ext > (W+F)'(FXMAX)) ? FXMAX : tol_ext[W-1:0];

	assign s_tready  = (st_q == S_IDLE);
	assign acc       = s_tvalid && s_tready;
	assign orig      = (variant_q == VAR_ORIG);
	assign force_par = orig && (iter_q < 10'd2);
	assign out_free  = !m_tvalid_q || m_tready;
	assign lim_hit   = (iter_q >= limit_q);
	assign span      = fsub(hi_q, lo_q);
	assign t1        = orig ? fadd(mp_q, ONE) : fadd(mp_q, tolf);
	assign conv_hit  = fabs(fsub(x_q, xm_q)) <= fsub(tol2_q, fhalf(span_q));
	assign para      = (fabs(e_q) > tol1_q) || force_par;
	assign gold_e    = (x_q >= xm_q) ? fsub(lo_q, x_q) : fsub(hi_q, x_q);
	assign c1        = fabs(p_q) >= fabs(fhalf(mp_q));
	assign c2        = p_q <= mp_q;
	assign c3        = p_q >= mp_q;
	assign u_div     = fadd(x_q, d_q);
	assign near      = (fsub(u_div, lo_q) < tol2_q) || (fsub(hi_q, u_div) < tol2_q);
	assign u_st1     = fadd(lo_q, mp_q);
	assign eval_inc  = (eval_q == {CNT_W{1'b1}}) ? eval_q : eval_q + CNT_W'(1);
	assign div_start = (st_q == S_P9) && !(c_q || c3);

	always_comb begin
		if (fabs(d_q) >= tol1_q) u_step = fadd(x_q, d_q);
		else if (orig ? (d_q >= 0) : (d_q > 0)) u_step = fadd(x_q, tol1_q);
		else u_step = fsub(x_q, tol1_q);
	end

	// operand select of the shared multiplier, product registered in mp_q
	always_comb begin
		case (st_q)
			S_HEAD:  begin ma = orig ? tolf : ONE;   mb = fabs(x_q);             end
			S_CHK:   begin ma = fsub(x_q, w_q);      mb = fsub(fx_q, fv_q);      end
			S_P1:    begin ma = fsub(x_q, v_q);      mb = fsub(fx_q, fw_q);      end
			S_P2:    begin ma = fsub(x_q, v_q);      mb = mp_q;                  end
			S_P3:    begin ma = fsub(x_q, w_q);      mb = r_q;                   end
			S_P6:    begin ma = q_q;                 mb = olde_q;                end
			S_P7:    begin ma = q_q;                 mb = fsub(lo_q, x_q);       end
			S_P8:    begin ma = q_q;                 mb = fsub(hi_q, x_q);       end
			S_GOLD:  begin ma = INVG;                mb = e_q;                   end
			default: begin ma = INVG;                mb = span;                  end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= S_IDLE;
		else st_q <= st_d;
	end

	always_comb begin
		st_d    = st_q;
		em_req  = 1'b0;
		em_done = 1'b0;
		em_conv = 1'b0;
		em_u    = u_step;
		case (st_q)
			S_IDLE: begin
				if (acc) begin
					if (s_tuser == OP_START) st_d = orig ? S_HEAD : S_ST1;
					else if (phase_q == PH_WAIT_INIT || phase_q == PH_WAIT_SAMPLE)
						st_d = S_HEAD;
				end
			end
			S_ST1: st_d = S_ST2;
			S_ST2: begin
				em_u = u_st1;
				if (out_free) begin
					em_req = 1'b1;
					st_d   = S_IDLE;
				end
			end
			S_HEAD: begin
				if (!lim_hit) st_d = S_TOL;
				else if (out_free) begin
					em_done = 1'b1;
					st_d    = S_IDLE;
				end
			end
			S_TOL: st_d = S_CHK;
			S_CHK: begin
				if (conv_hit) begin
					if (out_free) begin
						em_done = 1'b1;
						em_conv = 1'b1;
						st_d    = S_IDLE;
					end
				end else st_d = para ? S_P1 : S_GOLD;
			end
			S_P1: st_d = S_P2;
			S_P2: st_d = S_P3;
			S_P3: st_d = S_P4;
			S_P4: st_d = S_P5;
			S_P5: st_d = S_P6;
			S_P6: st_d = S_P7;
			S_P7: st_d = S_P8;
			S_P8: st_d = S_P9;
			S_P9: st_d = (c_q || c3) ? S_GOLD : S_DIV;
			S_GOLD: st_d = S_GOLD2;
			S_GOLD2: st_d = S_STEP;
			S_DIV: if (div_stat.done) st_d = S_DIVC;
			S_DIVC: st_d = S_STEP;
			S_STEP: begin
				if (out_free) begin
					em_req = 1'b1;
					st_d   = S_IDLE;
				end
			end
			default: st_d = S_IDLE;
		endcase
	end

	// control state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q      <= TOL_RESET;
			limit_q    <= LIMIT_RESET;
			variant_q  <= VAR_ORIG;
			phase_q    <= PH_IDLE;
			iter_q     <= '0;
			eval_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_TOL:     tol_q     <= cfg_data;
					REG_LIMIT:   limit_q   <= cfg_data[ITER_W-1:0];
					REG_VARIANT: variant_q <= cfg_data[0];
					default:     ;
				endcase
			end
			if (acc && s_tuser == OP_START) begin
				iter_q <= '0;
				eval_q <= '0;
			end else if (acc && phase_q == PH_WAIT_SAMPLE) begin
				iter_q <= iter_q + ITER_W'(1);
			end
			if (em_req) begin
				eval_q  <= eval_inc;
				phase_q <= (st_q == S_ST2) ? PH_WAIT_INIT : PH_WAIT_SAMPLE;
			end else if (em_done) begin
				phase_q <= PH_DONE;
			end
			if (em_req || em_done) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		mp_q <= fmul(ma, mb);
		case (st_q)
			S_IDLE: begin
				if (acc && s_tuser == OP_START) begin
					lo_q       <= in_lo;
					hi_q       <= in_hi;
					step_now_q <= '0;
					e_q        <= '0;
					x_q        <= in_m;
					fx_q       <= in_fm;
					if (in_fl <= in_fr) begin
						w_q <= in_l; fw_q <= in_fl; v_q <= in_r; fv_q <= in_fr;
					end else begin
						w_q <= in_r; fw_q <= in_fr; v_q <= in_l; fv_q <= in_fl;
					end
				end else if (acc && phase_q == PH_WAIT_INIT) begin
					x_q <= pend_q; w_q  <= pend_q; v_q  <= pend_q;
					fx_q <= in_fs; fw_q <= in_fs; fv_q <= in_fs;
				end else if (acc && phase_q == PH_WAIT_SAMPLE) begin
					if (in_fs <= fx_q) begin
						if (pend_q >= x_q) lo_q <= x_q;
						else hi_q <= x_q;
						v_q <= w_q; fv_q <= fw_q;
						w_q <= x_q; fw_q <= fx_q;
						x_q <= pend_q; fx_q <= in_fs;
					end else begin
						if (pend_q < x_q) lo_q <= pend_q;
						else hi_q <= pend_q;
						if (in_fs <= fw_q || w_q == x_q) begin
							v_q <= w_q; fv_q <= fw_q;
							w_q <= pend_q; fw_q <= in_fs;
						end else if (in_fs <= fv_q || v_q == x_q || v_q == w_q) begin
							v_q <= pend_q; fv_q <= in_fs;
						end
					end
				end
			end
			S_HEAD: begin
				span_q <= span;
				xm_q   <= fadd(lo_q, fhalf(span));
				if (force_par) e_q <= fadd(span, span);
			end
			S_TOL: begin
				tol1_q <= t1;
				tol2_q <= fadd(t1, t1);
			end
			S_CHK: if (!conv_hit && !para) e_q <= gold_e;
			S_P1: r_q <= mp_q;
			S_P2: q_q <= mp_q;
			S_P3: t_q <= mp_q;
			S_P4: begin
				p_q <= fsub(t_q, mp_q);
				q_q <= fadd(fsub(q_q, r_q), fsub(q_q, r_q));
			end
			S_P5: begin
				if (q_q > 0) p_q <= (p_q == FXMIN) ? FXMAX : -p_q;
				q_q    <= fabs(q_q);
				olde_q <= e_q;
				e_q    <= step_now_q;
			end
			S_P7: c_q <= c1;
			S_P8: c_q <= c_q || c2;
			S_P9: if (c_q || c3) e_q <= gold_e;
			S_GOLD2: d_q <= mp_q;
			S_DIV: if (div_stat.done) d_q <= div_quo;
			S_DIVC: if (near) d_q <= (x_q < xm_q) ? tol1_q : -tol1_q;
			S_STEP: if (out_free) begin
				step_now_q <= d_q;
				pend_q     <= u_step;
			end
			S_ST2: if (out_free) pend_q <= u_st1;
			default: ;
		endcase
		if (em_req || em_done) begin
			req_q  <= em_req ? out_word(em_u) : '0;
			done_q <= em_done;
			conv_q <= em_conv;
			bp_q   <= em_done ? out_word(x_q) : '0;
			bv_q   <= em_done ? out_word(fx_q) : '0;
			cnt_q  <= em_req ? eval_inc : eval_q;
		end
	end

	brent_div #(.W(W), .F(F)) u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (p_q),
		.den    (q_q),
		.quo    (div_quo),
		.stat   (div_stat)
	);

	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tuser   = done_q;
	assign m_tdata   = {4'b0, cnt_q, bv_q, bp_q, conv_q, req_q};

	a_done_no_request: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && done_q |-> req_q == '0)
		else $error("done beat carries a request point");

	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider started while busy");

	a_div_running: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_DIV |-> div_stat.busy || div_stat.done)
		else $error("waiting on an idle divider");

	a_done_phase: assert property (@(posedge clk) disable iff (!arst_n)
		em_done |=> phase_q == PH_DONE && m_tvalid_q)
		else $error("finished search not recorded");

endmodule

// ----- sim/tb_brent_line_minimizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_brent_line_minimizer
// Self-checking bench for the Brent line minimizer. Searches run against
// quadratic test functions (with noise and broken sequences mixed in),
// a fixed-point predictor mirrors the search and checks every result beat.
// ----------------------------------------------------------------------------
module tb_brent_line_minimizer;
	import brent_pkg::*;

	localparam longint WMAX = 64'sd2147483647;
	localparam longint WMIN = -64'sd2147483648;

	typedef struct {
		logic [31:0] req;
		logic        done;
		logic        conv;
		logic [31:0] bp;
		logic [31:0] bv;
		logic [10:0] cnt;
	} minimizer_result_t;

	class minimizer_scoreboard;
		longint tol_reg, limit_reg, variant_reg;
		longint lo_x, hi_x, bx, bfx, wx, wfx, vx, vfx, d_now, e_prev, pend;
		longint iter, evals;
		phase_t ph;
		minimizer_result_t awaited[$];
		int mismatches, results, searches, conv_cnt, limit_cnt;

		function new();
			tol_reg = TOL_RESET; limit_reg = LIMIT_RESET; variant_reg = VAR_ORIG;
			lo_x = 0; hi_x = 0; bx = 0; bfx = 0; wx = 0; wfx = 0; vx = 0; vfx = 0;
			d_now = 0; e_prev = 0; pend = 0; iter = 0; evals = 0; ph = PH_IDLE;
			mismatches = 0; results = 0; searches = 0; conv_cnt = 0; limit_cnt = 0;
		endfunction

		function longint sat(longint v);
			return v > WMAX ? WMAX : (v < WMIN ? WMIN : v);
		endfunction
		function longint fadd(longint a, longint b); return sat(a + b); endfunction
		function longint fsub(longint a, longint b); return sat(a - b); endfunction
		function longint fabs(longint v); return sat(v < 0 ? -v : v); endfunction
		function longint fhalf(longint v); return v / 2; endfunction

		function longint from_mag(bit neg, longint unsigned m);
			longint unsigned lim;
			lim = neg ? 64'd2147483648 : 64'd2147483647;
			if (m > lim) m = lim;
			return neg ? -longint'(m) : longint'(m);
		endfunction

		function longint fmul(longint a, longint b);
			longint unsigned x, y;
			x = a < 0 ? -a : a;
			y = b < 0 ? -b : b;
			return from_mag((a < 0) != (b < 0), (x * y) >> 16);
		endfunction

		function longint fdiv(longint p, longint q);
			longint unsigned up, uq;
			up = p < 0 ? -p : p;
			uq = q < 0 ? -q : q;
			if (uq == 0) return from_mag(p < 0, up != 0 ? 64'hFFFF_FFFF_FFFF : 0);
			return from_mag((p < 0) != (q < 0), (up << 16) / uq);
		endfunction

		function longint gold();
			longint unsigned g;
			g = ((64'd1640531527 << 16) + 64'h8000_0000) >> 32;
			return longint'(g);
		endfunction

		function void write_reg(logic [IDX_W-1:0] idx, logic [TOL_W-1:0] val);
			case (idx)
				REG_TOL: tol_reg = val;
				REG_LIMIT: limit_reg = val[ITER_W-1:0];
				REG_VARIANT: variant_reg = val[0];
				default: ;
			endcase
		endfunction

		function void push_result(longint req, bit done, bit conv);
			minimizer_result_t r;
			r.req = done ? 32'd0 : req[31:0];
			r.done = done;
			r.conv = done ? conv : 1'b0;
			r.bp = done ? bx[31:0] : 32'd0;
			r.bv = done ? bfx[31:0] : 32'd0;
			r.cnt = evals[10:0];
			awaited.push_back(r);
			if (done) begin
				if (conv) conv_cnt++;
				else limit_cnt++;
			end
		endfunction

		function void ask_point(longint u, phase_t nxt);
			pend = u;
			if (evals < 2047) evals++;
			ph = nxt;
			push_result(u, 0, 0);
		endfunction

		function void iterate();
			bit orig;
			longint span, xm, tol1, tol2, d, u, r, q, p, old_e;
			orig = variant_reg == 0;
			if (iter >= limit_reg) begin
				ph = PH_DONE; push_result(0, 1, 0); return;
			end
			span = fsub(hi_x, lo_x);
			if (orig && iter < 2) e_prev = fadd(span, span);
			xm = fadd(lo_x, fhalf(span));
			tol1 = orig ? fadd(fmul(tol_reg, fabs(bx)), 1) : fadd(fmul(1, fabs(bx)), tol_reg);
			tol2 = fadd(tol1, tol1);
			if (fabs(fsub(bx, xm)) <= fsub(tol2, fhalf(span))) begin
				ph = PH_DONE; push_result(0, 1, 1); return;
			end
			if (fabs(e_prev) > tol1 || (orig && iter < 2)) begin
				r = fmul(fsub(bx, wx), fsub(bfx, vfx));
				q = fmul(fsub(bx, vx), fsub(bfx, wfx));
				p = fsub(fmul(fsub(bx, vx), q), fmul(fsub(bx, wx), r));
				old_e = e_prev;
				q = fsub(q, r);
				q = fadd(q, q);
				if (q > 0) p = p == WMIN ? WMAX : -p;
				q = fabs(q);
				e_prev = d_now;
				if (fabs(p) >= fabs(fhalf(fmul(q, old_e))) || p <= fmul(q, fsub(lo_x, bx)) ||
						p >= fmul(q, fsub(hi_x, bx))) begin
					e_prev = bx >= xm ? fsub(lo_x, bx) : fsub(hi_x, bx);
					d = fmul(gold(), e_prev);
				end else begin
					d = fdiv(p, q);
					u = fadd(bx, d);
					if (fsub(u, lo_x) < tol2 || fsub(hi_x, u) < tol2) d = bx < xm ? tol1 : -tol1;
				end
			end else begin
				e_prev = bx >= xm ? fsub(lo_x, bx) : fsub(hi_x, bx);
				d = fmul(gold(), e_prev);
			end
			d_now = d;
			if (fabs(d) >= tol1) u = fadd(bx, d);
			else u = (orig ? d >= 0 : d > 0) ? fadd(bx, tol1) : fsub(bx, tol1);
			ask_point(u, PH_WAIT_SAMPLE);
		endfunction

		function void absorb(longint fu);
			longint u, x;
			u = pend; x = bx;
			if (fu <= bfx) begin
				if (u >= x) lo_x = x; else hi_x = x;
				vx = wx; vfx = wfx; wx = x; wfx = bfx; bx = u; bfx = fu;
			end else begin
				if (u < x) lo_x = u; else hi_x = u;
				if (fu <= wfx || wx == x) begin
					vx = wx; vfx = wfx; wx = u; wfx = fu;
				end else if (fu <= vfx || vx == x || vx == wx) begin
					vx = u; vfx = fu;
				end
			end
			iter = (iter + 1) & 10'h3FF;
		endfunction

		// returns 1 when the beat produces a result
		function bit note_input(logic op, logic [IN_DATA_W-1:0] dat);
			longint xa, xb, xc, fa, fb, fc, fs;
			xa = longint'($signed(dat[31:0]));    xb = longint'($signed(dat[63:32]));
			xc = longint'($signed(dat[95:64]));   fa = longint'($signed(dat[127:96]));
			fb = longint'($signed(dat[159:128])); fc = longint'($signed(dat[191:160]));
			fs = longint'($signed(dat[223:192]));
			if (op == OP_START) begin
				searches++;
				lo_x = xa < xc ? xa : xc;
				hi_x = xa > xc ? xa : xc;
				d_now = 0; e_prev = 0; iter = 0; evals = 0;
				if (variant_reg == VAR_ORIG) begin
					if (fa <= fc) begin
						wx = xa; wfx = fa; vx = xc; vfx = fc;
					end else begin
						wx = xc; wfx = fc; vx = xa; vfx = fa;
					end
					bx = xb; bfx = fb;
					iterate();
				end else begin
					ask_point(fadd(lo_x, fmul(gold(), fsub(hi_x, lo_x))), PH_WAIT_INIT);
				end
				return 1;
			end
			if (ph == PH_WAIT_INIT) begin
				bx = pend; wx = pend; vx = pend;
				bfx = fs; wfx = fs; vfx = fs;
				iterate();
				return 1;
			end
			if (ph == PH_WAIT_SAMPLE) begin
				absorb(fs);
				iterate();
				return 1;
			end
			return 0;
		endfunction

		function void check_result(logic [OUT_DATA_W-1:0] dat, logic usr);
			minimizer_result_t e;
			results++;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat: tdata=%h tuser=%b", dat, usr);
				return;
			end
			e = awaited.pop_front();
			if (dat[31:0] !== e.req || usr !== e.done || dat[32] !== e.conv ||
					dat[64:33] !== e.bp || dat[96:65] !== e.bv || dat[107:97] !== e.cnt) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"mismatch beat %0d: exp req=%h done=%b conv=%b bp=%h bv=%h ",
						"cnt=%0d | got req=%h done=%b conv=%b bp=%h bv=%h cnt=%0d"},
						results, e.req, e.done, e.conv, e.bp, e.bv, e.cnt,
						dat[31:0], usr, dat[32], dat[64:33], dat[96:65], dat[107:97]);
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [IDX_W-1:0]      cfg_index = '0;
	logic [TOL_W-1:0]      cfg_data = '0;

	minimizer_scoreboard sb = new();
	bit calm = 0;      // no random idling on either side
	bit hold_out = 0;  // long receiver stall
	int fed = 0;

	brent_line_minimizer u_top (.*);

	always #5 clk = ~clk;

	always @(negedge clk)
		m_tready = hold_out ? 1'b0 : (calm ? 1'b1 : ($urandom_range(99) >= 9));

	always @(posedge clk)
		if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);

	initial begin
		wait (sb.results >= 60);
		@(negedge clk);
		hold_out = 1;
		repeat (400) @(negedge clk);
		hold_out = 0;
	end

	initial begin
		#5ms;
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic put_beat(logic op, logic [IN_DATA_W-1:0] dat);
		if (!calm) begin
			while ($urandom_range(99) < 9) begin
				s_tvalid = 1'b0;
				@(negedge clk);
			end
		end
		s_tvalid = 1'b1;
		s_tuser = op;
		s_tdata = dat;
		do @(posedge clk); while (!s_tready);
		if (sb.note_input(op, dat)) fed++;
		@(negedge clk);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [TOL_W-1:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic settle();
		s_tvalid = 1'b0;
		while (sb.awaited.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	task automatic configure(int tol, int lim, int vr);
		settle();
		write_reg(REG_TOL, tol[15:0]);
		write_reg(REG_LIMIT, lim[15:0]);
		write_reg(REG_VARIANT, vr[15:0]);
	endtask

	function automatic logic [31:0] rnd32();
		return $urandom();
	endfunction

	// shifted, scaled parabola with an offset, saturating
	function automatic longint test_fn(longint x, longint ctr, longint k, longint off);
		return sb.fadd(sb.fmul(k, sb.fmul(sb.fsub(x, ctr), sb.fsub(x, ctr))), off);
	endfunction

	function automatic logic [IN_DATA_W-1:0] pack_in(longint a, longint b, longint c,
			longint fa, longint fb, longint fc, longint fs);
		return {fs[31:0], fc[31:0], fb[31:0], fa[31:0], c[31:0], b[31:0], a[31:0]};
	endfunction

	task automatic run_search();
		longint ctr, k, off, sp, a, b, c, fs;
		int shape;
		ctr = sb.sat(longint'($signed(rnd32())) >>> $urandom_range(16, 0));
		k = $urandom_range(3) == 0 ? longint'($signed(rnd32())) >>> $urandom_range(28, 8)
				: longint'($urandom_range(65536 * 4, 1));
		off = longint'($signed(rnd32())) >>> $urandom_range(20, 0);
		sp = longint'($urandom_range(32'h7FFF_FFFF, 1)) >> $urandom_range(30, 4);
		if (sp == 0) sp = 1;
		a = sb.fsub(ctr, sp * $urandom_range(4, 1) / 2);
		c = sb.fadd(ctr, sp * $urandom_range(4, 1) / 2);
		b = a + (c - a) * $urandom_range(9, 1) / 10;
		shape = $urandom_range(15);
		if (shape == 0) begin
			a = longint'($signed(rnd32())); b = longint'($signed(rnd32()));
			c = longint'($signed(rnd32()));
		end else if (shape == 1) begin
			fs = a; a = c; c = fs;
		end
		put_beat(OP_START, pack_in(a, b, c, test_fn(a, ctr, k, off), test_fn(b, ctr, k, off),
			test_fn(c, ctr, k, off), longint'($signed(rnd32()))));
		while ((sb.ph == PH_WAIT_INIT || sb.ph == PH_WAIT_SAMPLE) && fed < 850) begin
			if ($urandom_range(199) == 0) return;  // abandon mid-search
			fs = $urandom_range(15) == 0 ? longint'($signed(rnd32())) : test_fn(sb.pend, ctr, k, off);
			put_beat(OP_SAMPLE, pack_in(rnd32(), rnd32(), rnd32(), rnd32(), rnd32(), rnd32(), fs));
		end
		if ($urandom_range(9) == 0)
			put_beat(OP_SAMPLE, pack_in(rnd32(), rnd32(), rnd32(), rnd32(), rnd32(), rnd32(),
				rnd32()));
	endtask

	task automatic walk(int steps, longint fs);
		repeat (steps)
			if (sb.ph == PH_WAIT_INIT || sb.ph == PH_WAIT_SAMPLE)
				put_beat(OP_SAMPLE, pack_in(-1, -1, -1, -1, -1, -1, fs));
	endtask

	initial begin
		int cfg_phase;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: sample with no search, extreme brackets, flat values, reversed bracket
		put_beat(OP_SAMPLE, pack_in(WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX));
		put_beat(OP_START, pack_in(WMIN, 0, WMAX, WMAX, WMIN, WMAX, WMIN));
		walk(3, WMIN);
		put_beat(OP_START, pack_in(WMAX, 0, WMIN, 0, 0, 0, 0));
		walk(3, 0);
		put_beat(OP_START, pack_in(-1, -1, -1, -1, -1, -1, -1));
		walk(2, WMAX);
		configure(0, 1, 1);
		put_beat(OP_START, pack_in(65536, 0, -65536, 5, 3, 5, 0));
		walk(2, 7);
		put_beat(OP_SAMPLE, pack_in(0, 0, 0, 0, 0, 0, 0));
		configure(65535, 1023, 0);
		put_beat(OP_START, pack_in(-65536, 0, 65536, 65536, 0, 65536, 0));
		walk(4, 1);
		configure(0, 1023, 1);
		put_beat(OP_START, pack_in(WMIN, WMAX, WMAX, WMIN, WMIN, WMIN, WMAX));
		walk(3, WMIN);

		cfg_phase = 0;
		while (fed < 850) begin
			case (cfg_phase % 6)
				0: configure(66, 100, 0);
				1: configure(0, 1023, 0);
				2: configure(65535, 1, 1);
				3: configure(0, 1023, 1);
				4: configure($urandom_range(65535), $urandom_range(40, 1), 0);
				default: configure($urandom_range(2000), $urandom_range(1023, 1), 1);
			endcase
			calm = cfg_phase == 1;
			repeat (6) run_search();
			cfg_phase++;
		end
		calm = 0;
		settle();
		$display("searches started: %0d, beats with results: %0d, result beats checked: %0d",
			sb.searches, fed, sb.results);
		$display("searches ended converged: %0d, at iteration limit: %0d",
			sb.conv_cnt, sb.limit_cnt);
		if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("mismatches: %0d, results still awaited: %0d", sb.mismatches,
				sb.awaited.size());
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ----- files.f -----
src/brent_pkg.sv
src/brent_div.sv
src/brent_line_minimizer.sv
sim/tb_brent_line_minimizer.sv
